// File: sv/qxm_pkg.sv
// ============================================================================
// qxm_pkg: shared types, constants and helper functions of the quad-X mixer
// Widths of the mixing datapath, the pipeline stage record, register codes,
// and the small arithmetic helpers used by the pipeline stages.
// ============================================================================
package qxm_pkg;

    // Field widths
    localparam int THR_W    = 12;               // throttle, us
    localparam int TRQ_W    = 16;               // torques, 1/16 us, signed
    localparam int LIM_W    = 12;               // pulse limits, us
    localparam int MOT_W    = 12;               // motor outputs, us
    localparam int SUM_W    = 19;               // 16*T +- R +- P +- Y, signed
    localparam int F_W      = 15;               // mixed width in us, signed
    localparam int V_W      = 14;               // violation magnitude
    localparam int WORST_W  = 14;               // positive worst width
    localparam int PROD_W   = WORST_W + LIM_W;  // width * limit
    localparam int QUO_W    = 12;               // quotient bits below the overflow mark
    localparam int NUM_MOT  = 4;

    // Stream and config port widths
    localparam int S_DATA_W  = 64;   // 60 payload bits, padded to bytes
    localparam int M_DATA_W  = 56;   // 49 payload bits, padded to bytes
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam logic [LIM_W-1:0] LOW_RESET  = 12'd1000;
    localparam logic [LIM_W-1:0] HIGH_RESET = 12'd1990;

    // Pipeline layout
    localparam int STEPS_PER_STG = 4;
    localparam int DIV_STGS      = QUO_W / STEPS_PER_STG;
    localparam int ST_MIX        = 0;
    localparam int ST_VIOL       = 1;
    localparam int ST_SEL        = 2;
    localparam int ST_MUL        = 3;
    localparam int ST_OVF        = 4;
    localparam int ST_DIV0       = 5;
    localparam int ST_OUT        = ST_DIV0 + DIV_STGS;
    localparam int NUM_STG       = ST_OUT + 1;

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT  = 1'b0,
        CFG_HIGH_LIMIT = 1'b1
    } t_cfg_reg;

    // Record carried by every pipeline stage before the output register (unused fields trim away)
    typedef struct packed {
        logic [NUM_MOT-1:0][F_W-1:0]    f;         // mixed widths, signed
        logic [NUM_MOT-1:0]             over;      // width above high limit
        logic [NUM_MOT-1:0][V_W-1:0]    viol;      // violation magnitude
        logic                           sat;
        logic                           do_scale;
        logic [WORST_W-1:0]             worst;
        logic [LIM_W-1:0]               limit;
        logic [NUM_MOT-1:0]             pos;       // width strictly positive
        logic [NUM_MOT-1:0]             ovf;       // quotient >= 2**QUO_W
        logic [NUM_MOT-1:0][PROD_W-1:0] div;       // product, then rem/quotient
    } t_stage;

    // Divide by 16 with truncation toward zero
    function automatic logic signed [F_W-1:0] div16(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] adj;
        logic signed [SUM_W-1:0] shr;
        adj = s[SUM_W-1] ? (s + SUM_W'(15)) : s;
        shr = adj >>> 4;
        return shr[F_W-1:0];
    endfunction

    // One restoring division step: word = {remainder, dividend low bits / quotient}
    function automatic logic [PROD_W-1:0] div_step(input logic [PROD_W-1:0] w,
                                                   input logic [WORST_W-1:0] d);
        logic [WORST_W:0] t;
        logic [WORST_W:0] diff;
        t    = w[PROD_W-1:QUO_W-1];
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {diff[WORST_W-1:0], w[QUO_W-2:0], 1'b1};
        end else begin
            return {t[WORST_W-1:0], w[QUO_W-2:0], 1'b0};
        end
    endfunction

    // Clamp: below low gives low, otherwise above high gives high
    function automatic logic [MOT_W-1:0] clamp(input logic signed [F_W-1:0] v,
                                               input logic [LIM_W-1:0] lo,
                                               input logic [LIM_W-1:0] hi);
        logic signed [F_W-1:0] lo_s;
        logic signed [F_W-1:0] hi_s;
        lo_s = $signed({{(F_W-LIM_W){1'b0}}, lo});
        hi_s = $signed({{(F_W-LIM_W){1'b0}}, hi});
        if (v < lo_s) begin
            return lo;
        end else if (v > hi_s) begin
            return hi;
        end else begin
            return v[MOT_W-1:0];
        end
    endfunction

endpackage

// File: sv/quad_x_mixer_with_saturation.sv
// ============================================================================
// quad_x_mixer_with_saturation: quad-X motor mixer with collective saturation
// Mixes throttle and roll/pitch/yaw torques into four pulse widths, rescales all
// four when one breaks the limits and the worst is positive, clamps, flags saturation.
// ============================================================================
// The block takes one command set per clock while s_axis_tready is high and
// returns one result per command, which is taken when the output side is
// ready. The pipeline has nine register stages: mixing, limit check,
// worst-motor select, multiply by the broken limit, an overflow check,
// three stages of a restoring divider (four quotient bits each, one divider
// per motor) and the clamp into the output register. Each stage holds its
// request while the stage after it is full and cannot move on, and moves up
// into any bubble, so a stall on the result side drops or repeats nothing.
// The limit registers are written through the config channel, which is
// always ready.
module quad_x_mixer_with_saturation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [11:0] throttle, [27:12] torque_roll, [43:28] torque_pitch,
    // [59:44] torque_yaw, [63:60] zero
    input  logic [qxm_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [11:0] motor_one, [23:12] motor_two, [35:24] motor_three,
    // [47:36] motor_four, [48] was_saturated, [55:49] zero
    output logic [qxm_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // Config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qxm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qxm_pkg::LIM_W-1:0]      i_cfg_data
);

    localparam int NS = qxm_pkg::NUM_STG;

    logic [qxm_pkg::LIM_W-1:0] r_lo;
    logic [qxm_pkg::LIM_W-1:0] r_hi;

    logic [NS-1:0]             r_vld;
    logic [NS-1:0]             en;
    qxm_pkg::t_stage           r_stg [qxm_pkg::ST_OUT];
    qxm_pkg::t_stage           n_stg [qxm_pkg::ST_OUT];
    logic [qxm_pkg::M_DATA_W-1:0] r_out;
    logic [qxm_pkg::M_DATA_W-1:0] n_out;
    logic                      rem_ok;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= qxm_pkg::LOW_RESET;
            r_hi <= qxm_pkg::HIGH_RESET;
        end else if (i_cfg_valid) begin
            case (qxm_pkg::t_cfg_reg'(i_cfg_index))
                qxm_pkg::CFG_LOW_LIMIT:  r_lo <= i_cfg_data;
                qxm_pkg::CFG_HIGH_LIMIT: r_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = r_out;

    // Stage logic
    always_comb begin
        logic [qxm_pkg::THR_W-1:0]        thr;
        logic signed [qxm_pkg::SUM_W-1:0] t16;
        logic signed [qxm_pkg::SUM_W-1:0] tr;
        logic signed [qxm_pkg::SUM_W-1:0] tp;
        logic signed [qxm_pkg::SUM_W-1:0] ty;
        logic signed [qxm_pkg::F_W-1:0]   fi;
        logic signed [qxm_pkg::F_W-1:0]   lo_s;
        logic signed [qxm_pkg::F_W-1:0]   hi_s;
        logic signed [qxm_pkg::F_W-1:0]   d;
        logic [qxm_pkg::NUM_MOT-1:0]      under;
        logic [qxm_pkg::V_W-1:0]          best;
        logic [1:0]                       j;
        logic signed [qxm_pkg::F_W-1:0]   fj;
        logic signed [qxm_pkg::F_W-1:0]   cand;
        logic [qxm_pkg::NUM_MOT-1:0][qxm_pkg::MOT_W-1:0] mot;

        lo_s = $signed({{(qxm_pkg::F_W-qxm_pkg::LIM_W){1'b0}}, r_lo});
        hi_s = $signed({{(qxm_pkg::F_W-qxm_pkg::LIM_W){1'b0}}, r_hi});

        // Mix: quad-X sign pattern in 1/16 us, then truncate to whole us
        n_stg[qxm_pkg::ST_MIX] = '0;
        thr = s_axis_tdata[11:0];
        t16 = $signed({3'b000, thr, 4'b0000});
        tr  = $signed({{3{s_axis_tdata[27]}}, s_axis_tdata[27:12]});
        tp  = $signed({{3{s_axis_tdata[43]}}, s_axis_tdata[43:28]});
        ty  = $signed({{3{s_axis_tdata[59]}}, s_axis_tdata[59:44]});
        n_stg[qxm_pkg::ST_MIX].f[0] = qxm_pkg::div16(t16 - tr - tp - ty);
        n_stg[qxm_pkg::ST_MIX].f[1] = qxm_pkg::div16(t16 - tr + tp + ty);
        n_stg[qxm_pkg::ST_MIX].f[2] = qxm_pkg::div16(t16 + tr + tp - ty);
        n_stg[qxm_pkg::ST_MIX].f[3] = qxm_pkg::div16(t16 + tr - tp + ty);

        // Limit check and violation size
        n_stg[qxm_pkg::ST_VIOL] = r_stg[qxm_pkg::ST_VIOL-1];
        under = '0;
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            fi = $signed(r_stg[qxm_pkg::ST_VIOL-1].f[i]);
            n_stg[qxm_pkg::ST_VIOL].over[i] = 1'b0;
            if (fi > hi_s) begin
                n_stg[qxm_pkg::ST_VIOL].over[i] = 1'b1;
                d = fi - hi_s;
            end else if (fi < lo_s) begin
                under[i] = 1'b1;
                d = lo_s - fi;
            end else begin
                d = '0;
            end
            n_stg[qxm_pkg::ST_VIOL].viol[i] = d[qxm_pkg::V_W-1:0];
        end
        n_stg[qxm_pkg::ST_VIOL].sat = |(n_stg[qxm_pkg::ST_VIOL].over | under);

        // Worst motor: first one with the strictly largest violation
        n_stg[qxm_pkg::ST_SEL] = r_stg[qxm_pkg::ST_SEL-1];
        best = '0;
        j    = '0;
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            if (r_stg[qxm_pkg::ST_SEL-1].viol[i] > best) begin
                best = r_stg[qxm_pkg::ST_SEL-1].viol[i];
                j    = 2'(i);
            end
        end
        fj = $signed(r_stg[qxm_pkg::ST_SEL-1].f[j]);
        n_stg[qxm_pkg::ST_SEL].limit    = r_stg[qxm_pkg::ST_SEL-1].over[j] ? r_hi : r_lo;
        n_stg[qxm_pkg::ST_SEL].do_scale = r_stg[qxm_pkg::ST_SEL-1].sat && (fj > 0);
        n_stg[qxm_pkg::ST_SEL].worst    = fj[qxm_pkg::WORST_W-1:0];

        // Width times broken limit
        n_stg[qxm_pkg::ST_MUL] = r_stg[qxm_pkg::ST_MUL-1];
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            n_stg[qxm_pkg::ST_MUL].pos[i] = $signed(r_stg[qxm_pkg::ST_MUL-1].f[i]) > 0;
            n_stg[qxm_pkg::ST_MUL].div[i] =
                r_stg[qxm_pkg::ST_MUL-1].f[i][qxm_pkg::WORST_W-1:0]
                * r_stg[qxm_pkg::ST_MUL-1].limit;
        end

        // Quotient overflow: product >= worst * 2**QUO_W
        n_stg[qxm_pkg::ST_OVF] = r_stg[qxm_pkg::ST_OVF-1];
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            n_stg[qxm_pkg::ST_OVF].ovf[i] = r_stg[qxm_pkg::ST_OVF-1].div[i]
                >= {r_stg[qxm_pkg::ST_OVF-1].worst, {qxm_pkg::QUO_W{1'b0}}};
        end

        // Restoring divider, four quotient bits per stage
        for (int s = qxm_pkg::ST_DIV0; s < qxm_pkg::ST_OUT; s++) begin
            n_stg[s] = r_stg[s-1];
            for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
                for (int b = 0; b < qxm_pkg::STEPS_PER_STG; b++) begin
                    n_stg[s].div[i] = qxm_pkg::div_step(n_stg[s].div[i], r_stg[s-1].worst);
                end
            end
        end

        // Select scaled or plain width, clamp, pack the result
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            if (!r_stg[qxm_pkg::ST_OUT-1].do_scale) begin
                cand = $signed(r_stg[qxm_pkg::ST_OUT-1].f[i]);
            end else if (!r_stg[qxm_pkg::ST_OUT-1].pos[i]) begin
                cand = '0;
            end else if (r_stg[qxm_pkg::ST_OUT-1].ovf[i]) begin
                cand = $signed(qxm_pkg::F_W'(1) << qxm_pkg::QUO_W);
            end else begin
                cand = $signed({{(qxm_pkg::F_W-qxm_pkg::QUO_W){1'b0}},
                                r_stg[qxm_pkg::ST_OUT-1].div[i][qxm_pkg::QUO_W-1:0]});
            end
            mot[i] = qxm_pkg::clamp(cand, r_lo, r_hi);
        end
        n_out = {7'b0, r_stg[qxm_pkg::ST_OUT-1].sat, mot[3], mot[2], mot[1], mot[0]};
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < qxm_pkg::ST_OUT; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
        if (en[NS-1]) begin
            r_out <= n_out;
        end
    end

    // Divider remainder check on the last divider stage
    always_comb begin
        rem_ok = 1'b1;
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            if (!r_stg[qxm_pkg::ST_OUT-1].ovf[i] &&
                (r_stg[qxm_pkg::ST_OUT-1].div[i][qxm_pkg::PROD_W-1:qxm_pkg::QUO_W]
                 >= r_stg[qxm_pkg::ST_OUT-1].worst)) begin
                rem_ok = 1'b0;
            end
        end
    end

    // Assertions
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_scale_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[qxm_pkg::ST_SEL] && r_stg[qxm_pkg::ST_SEL].do_scale
            |-> r_stg[qxm_pkg::ST_SEL].sat)
        else $error("rescale chosen for a request that is not saturated");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[qxm_pkg::ST_OUT-1] && r_stg[qxm_pkg::ST_OUT-1].do_scale |-> rem_ok)
        else $error("divider remainder not below the divisor");

    a_entry_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> s_axis_tready)
        else $error("input stalled with an empty first stage");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[qxm_pkg::ST_OUT-1] && !en[qxm_pkg::ST_OUT-1] |=> m_axis_tvalid)
        else $error("stalled request lost before the output register");

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench: self-checking bench for the quad-X mixer with saturation
// Drives command sets on the input stream and computes the expected motor
// widths and saturation flag in a local mixer model. Each result on the
// output stream is checked field by field against the oldest pending
// prediction. Covers the corner cases, a sweep of pulse limit settings and
// random commands under varying backpressure on both streams.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES = 16;    // settle time after the last result

    // Expected motor outputs for one command set
    typedef struct packed {
        logic [qxm_pkg::MOT_W-1:0] motor_one;
        logic [qxm_pkg::MOT_W-1:0] motor_two;
        logic [qxm_pkg::MOT_W-1:0] motor_three;
        logic [qxm_pkg::MOT_W-1:0] motor_four;
        logic                      was_saturated;
    } t_mix_result;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [11:0] throttle, [27:12] torque_roll, [43:28] torque_pitch,
    // [59:44] torque_yaw, [63:60] zero
    logic [qxm_pkg::S_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [11:0] motor_one, [23:12] motor_two, [35:24] motor_three,
    // [47:36] motor_four, [48] was_saturated, [55:49] zero
    logic [qxm_pkg::M_DATA_W-1:0]    m_axis_tdata;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [qxm_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [qxm_pkg::LIM_W-1:0]       i_cfg_data    = '0;

    // Local copy of the limit registers
    logic [qxm_pkg::LIM_W-1:0]       cur_low       = qxm_pkg::LOW_RESET;
    logic [qxm_pkg::LIM_W-1:0]       cur_high      = qxm_pkg::HIGH_RESET;

    t_mix_result           expected_mix[$];
    int                    fail_count    = 0;
    int                    quiet_cycles  = 0;
    int                    tx_idle_pct   = 28;
    int                    rx_idle_pct   = 73;

    quad_x_mixer_with_saturation DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Mixer model: quad-X mix, worst-motor rescale, clamp
    function automatic t_mix_result predict_mix(input logic [qxm_pkg::THR_W-1:0] thr,
                                                input logic [qxm_pkg::TRQ_W-1:0] roll,
                                                input logic [qxm_pkg::TRQ_W-1:0] pitch,
                                                input logic [qxm_pkg::TRQ_W-1:0] yaw,
                                                input logic [qxm_pkg::LIM_W-1:0] lo_lim,
                                                input logic [qxm_pkg::LIM_W-1:0] hi_lim);
        longint      t16, r, p, y, lo, hi, best, viol, lim, worst;
        longint      w [qxm_pkg::NUM_MOT];
        logic        sat;
        int          j;
        t_mix_result res;
        t16 = longint'(thr) * 16;
        r   = longint'($signed(roll));
        p   = longint'($signed(pitch));
        y   = longint'($signed(yaw));
        lo  = longint'(lo_lim);
        hi  = longint'(hi_lim);
        // Division truncates toward zero, same as the hardware
        w[0] = (t16 - r - p - y) / 16;
        w[1] = (t16 - r + p + y) / 16;
        w[2] = (t16 + r + p - y) / 16;
        w[3] = (t16 + r - p + y) / 16;
        sat = 1'b0;
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            if (w[i] < lo || w[i] > hi) begin
                sat = 1'b1;
            end
        end
        if (sat) begin
            // First motor with the strictly largest violation
            best = 0;
            j    = 0;
            for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
                viol = 0;
                if (w[i] > hi) begin
                    viol = w[i] - hi;
                end else if (w[i] < lo) begin
                    viol = lo - w[i];
                end
                if (viol > best) begin
                    best = viol;
                    j    = i;
                end
            end
            if (w[j] > hi) begin
                lim = hi;
            end else if (w[j] < lo) begin
                lim = lo;
            end else begin
                lim = w[j];
            end
            // No rescale when the worst width is zero or negative
            if (w[j] > 0 && lim != w[j]) begin
                worst = w[j];
                for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
                    w[i] = (w[i] * lim) / worst;
                end
            end
        end
        for (int i = 0; i < qxm_pkg::NUM_MOT; i++) begin
            if (w[i] < lo) begin
                w[i] = lo;
            end else if (w[i] > hi) begin
                w[i] = hi;
            end
        end
        res.motor_one     = qxm_pkg::MOT_W'(w[0]);
        res.motor_two     = qxm_pkg::MOT_W'(w[1]);
        res.motor_three   = qxm_pkg::MOT_W'(w[2]);
        res.motor_four    = qxm_pkg::MOT_W'(w[3]);
        res.was_saturated = sat;
        return res;
    endfunction

    // Torque with a random magnitude class so small and huge values both show up
    function automatic logic [qxm_pkg::TRQ_W-1:0] rand_torque();
        int mag;
        mag = 1 << $urandom_range(15, 0);
        return qxm_pkg::TRQ_W'(int'($urandom_range(2 * mag - 1)) - mag);
    endfunction

    // Send one command request, predict its result once accepted
    task automatic send_command(input logic [qxm_pkg::THR_W-1:0] thr,
                                input logic [qxm_pkg::TRQ_W-1:0] roll,
                                input logic [qxm_pkg::TRQ_W-1:0] pitch,
                                input logic [qxm_pkg::TRQ_W-1:0] yaw);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, yaw, pitch, roll, thr};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_mix.push_back(predict_mix(thr, roll, pitch, yaw, cur_low, cur_high));
    endtask

    // Hold off the input until every pending result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_mix.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Write both limit registers while the pipeline is empty
    task automatic set_limits(input logic [qxm_pkg::LIM_W-1:0] lo,
                              input logic [qxm_pkg::LIM_W-1:0] hi);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= qxm_pkg::CFG_LOW_LIMIT;
        i_cfg_data  <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_low     = lo;
        i_cfg_index <= qxm_pkg::CFG_HIGH_LIMIT;
        i_cfg_data  <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_high    = hi;
        i_cfg_valid <= 1'b0;
    endtask

    // Corner cases under the reset limits
    task automatic test_reset_limits();
        send_command(12'd0,    16'sd0,      16'sd0,      16'sd0);      // worst width zero
        send_command(12'd1500, 16'sd0,      16'sd0,      16'sd0);      // in range
        send_command(12'd1000, 16'sd0,      16'sd0,      16'sd0);      // on low limit
        send_command(12'd1990, 16'sd0,      16'sd0,      16'sd0);      // on high limit
        send_command(12'd4095, 16'sd0,      16'sd0,      16'sd0);      // four-way tie
        send_command(12'd4095, 16'h8000,    16'h8000,    16'h8000);
        send_command(12'd4095, 16'h7FFF,    16'h7FFF,    16'h7FFF);
        send_command(12'd0,    16'h7FFF,    16'sd0,      16'sd0);      // worst negative
        send_command(12'd0,    16'h8000,    16'h8000,    16'h8000);
        send_command(12'd4095, 16'h8000,    16'h7FFF,    16'h8000);
        send_command(12'd1500, 16'sd9600,   16'sd0,      16'sd0);      // high side wins
        send_command(12'd1495, 16'sd8080,   16'sd0,      16'sd0);      // equal violations
        send_command(12'd1000, 16'sd1,      16'sd0,      16'sd0);      // truncation down
        send_command(12'd0,    16'sd1,      16'sd0,      16'sd0);      // truncation to zero
        send_command(12'd0,    -16'sd17,    16'sd0,      16'sd0);
        send_command(12'd1500, 16'sd0,      16'sd12000,  16'sd0);      // pitch only
        send_command(12'd1500, 16'sd0,      16'sd0,      -16'sd12000); // yaw only
        send_command(12'd2000, 16'sd160,    -16'sd320,   16'sd480);
        send_command(12'hAAA,  16'h5555,    16'hAAAA,    16'h5555);
        send_command(12'h555,  16'hAAAA,    16'h5555,    16'hAAAA);
    endtask

    // Random commands: mostly flight-like, some full range, near the limits or at edge throttles
    task automatic test_random_commands(input int count);
        logic [qxm_pkg::THR_W-1:0] thr;
        logic [qxm_pkg::TRQ_W-1:0] roll, pitch, yaw;
        for (int n = 0; n < count; n++) begin
            roll  = rand_torque();
            pitch = rand_torque();
            yaw   = rand_torque();
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    thr = qxm_pkg::THR_W'($urandom_range(2300, 700));
                end
                5, 6: begin
                    thr   = qxm_pkg::THR_W'($urandom);
                    roll  = qxm_pkg::TRQ_W'($urandom);
                    pitch = qxm_pkg::TRQ_W'($urandom);
                    yaw   = qxm_pkg::TRQ_W'($urandom);
                end
                7: begin
                    thr = $urandom_range(1) ? cur_low : cur_high;
                    thr = thr + qxm_pkg::THR_W'(int'($urandom_range(4)) - 2);
                end
                default: begin
                    thr = $urandom_range(1) ? '1 : '0;
                    if ($urandom_range(1)) begin
                        pitch = '0;
                        yaw   = '0;
                    end
                end
            endcase
            send_command(thr, roll, pitch, yaw);
            if (n == count / 2) begin
                drain_results();
            end
        end
    endtask

    // Sweep of limit settings, extremes and crossed limits included
    task automatic test_limit_settings(input int per_setting);
        logic [qxm_pkg::LIM_W-1:0] lows  [7] = '{12'd0,    12'd4095, 12'd0, 12'd4095,
                                                 12'd1100, 12'd1990, 12'd0};
        logic [qxm_pkg::LIM_W-1:0] highs [7] = '{12'd4095, 12'd0,    12'd0, 12'd4095,
                                                 12'd1900, 12'd1000, 12'd0};
        for (int k = 0; k < 7; k++) begin
            if (k == 6) begin
                lows[k]  = qxm_pkg::LIM_W'($urandom);
                highs[k] = qxm_pkg::LIM_W'($urandom);
            end
            set_limits(lows[k], highs[k]);
            test_random_commands(per_setting);
        end
        set_limits(qxm_pkg::LOW_RESET, qxm_pkg::HIGH_RESET);
    endtask

    // Output side backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result check against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_mix_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_mix.size() == 0) begin
                $error("unexpected result request: tdata=%h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_mix.pop_front();
                check_field("motor_one",     int'(want.motor_one),
                            int'(m_axis_tdata[11:0]));
                check_field("motor_two",     int'(want.motor_two),
                            int'(m_axis_tdata[23:12]));
                check_field("motor_three",   int'(want.motor_three),
                            int'(m_axis_tdata[35:24]));
                check_field("motor_four",    int'(want.motor_four),
                            int'(m_axis_tdata[47:36]));
                check_field("was_saturated", int'(want.was_saturated),
                            int'(m_axis_tdata[48]));
            end
        end
    end

    // Watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender lightly idle, receiver heavily stalled
        test_reset_limits();
        test_random_commands(250);

        // Roles swapped
        drain_results();
        tx_idle_pct = 73;
        rx_idle_pct = 28;
        test_limit_settings(50);

        // Full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_commands(330);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_mix.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
